// ----- src/xor_delta_zero_rle_encoder_assert.svh -----
// assertion macros shared by the encoder checker
`ifndef XOR_DELTA_ZERO_RLE_ENCODER_ASSERT_SVH
`define XOR_DELTA_ZERO_RLE_ENCODER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define XDZR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("xdzr same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define XDZR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("xdzr next-cycle check failed");

// same-cycle implication that also holds during reset
`define XDZR_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("xdzr reset check failed");

`endif

// ----- src/xdzr_pkg.sv -----
// types and constants for the xor delta zero run encoder
package xdzr_pkg;

  localparam logic [7:0] RUN_MARKER = 8'h00;
  localparam logic [7:0] CNT_SAT    = 8'hFF;
  localparam int unsigned MAX_OUT   = 3;

  typedef struct packed {
    logic [7:0] base_byte;
    logic [7:0] cur_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       item_last;
    logic       frame_end;
  } out_item_t;

  // encoded bytes caused by one input item
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [1:0]              count;
    logic                    frame_last;
  } burst_t;

endpackage

// ----- src/xor_delta_zero_rle_encoder.sv -----
// top level of the xor delta zero run length encoder
//
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_ready_o    | in_item_i  (base, cur, frame_last)
//  out     | output    | out_valid_o / out_ready_i  | out_item_o (byte, item_last, frame_end)
//
// an item is held in the input register, then its zero to three bytes
// are loaded into the result buffer and leave one per cycle while out_ready_i is high
// items are paced by the result buffer, which must send all bytes of an item before it loads the next
// a new item is taken while the last byte of the previous one is taken
// reset clears the run count and both valid flags
// out stalls hold the buffer and back up into the input register
module xor_delta_zero_rle_encoder
  import xdzr_pkg::*;
#(
  parameter int unsigned MAX_RUN = 255
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic       s1_valid_q, s1_valid_d;
  in_item_t   s1_item_q;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] cnt_enc;
  burst_t     burst;
  burst_t     buf_q;
  logic       buf_valid_q, buf_valid_d;
  logic [1:0] idx_q, idx_d;
  logic       out_fire, buf_tail, buf_done, load;

  xdzr_encode #(
    .MAX_RUN(MAX_RUN)
  ) u_encode (
    .item_i (s1_item_q),
    .cnt_i  (cnt_q),
    .burst_o(burst),
    .cnt_o  (cnt_enc)
  );

  assign out_fire   = out_valid_o && out_ready_i;
  assign buf_tail   = (idx_q == buf_q.count - 2'd1);
  assign buf_done   = out_fire && buf_tail;
  assign load       = s1_valid_q && (!buf_valid_q || buf_done);
  assign in_ready_o = !s1_valid_q || load;

  assign out_valid_o          = buf_valid_q;
  assign out_item_o.out_byte  = buf_q.bytes[idx_q];
  assign out_item_o.item_last = buf_tail;
  assign out_item_o.frame_end = buf_tail && buf_q.frame_last;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    buf_valid_d = buf_valid_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
    if (buf_done) begin
      buf_valid_d = 1'b0;
    end else if (out_fire) begin
      idx_d = idx_q + 2'd1;
    end
    if (load) begin
      cnt_d       = cnt_enc;
      idx_d       = 2'd0;
      // zero bytes inside a run produce nothing to buffer
      buf_valid_d = (burst.count != 2'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      buf_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      cnt_q       <= 8'd0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      buf_valid_q <= buf_valid_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
    if (load) begin
      buf_q <= burst;
    end
  end

endmodule

// ----- src/xdzr_encode.sv -----
// combinational encoding of one byte pair against the pending zero run
module xdzr_encode
  import xdzr_pkg::*;
#(
  parameter int unsigned MAX_RUN = 255
) (
  input  in_item_t   item_i,
  input  logic [7:0] cnt_i,
  output burst_t     burst_o,
  output logic [7:0] cnt_o
);

  logic [7:0] x;
  logic [7:0] cnt_inc;
  logic [7:0] cnt_after;

  assign x       = item_i.base_byte ^ item_i.cur_byte;
  assign cnt_inc = (cnt_i == CNT_SAT) ? cnt_i : cnt_i + 8'd1;

  always_comb begin
    burst_o.bytes      = '0;
    burst_o.count      = 2'd0;
    burst_o.frame_last = item_i.frame_last;
    cnt_after          = cnt_i;
    if (x == 8'h00) begin
      // full run or frame end flushes the run once
      if (cnt_inc >= 8'(MAX_RUN) || item_i.frame_last) begin
        burst_o.bytes[0] = RUN_MARKER;
        burst_o.bytes[1] = cnt_inc;
        burst_o.count    = 2'd2;
        cnt_after        = 8'd0;
      end else begin
        cnt_after = cnt_inc;
      end
    end else begin
      if (cnt_i != 8'd0) begin
        burst_o.bytes[0] = RUN_MARKER;
        burst_o.bytes[1] = cnt_i;
        burst_o.bytes[2] = x;
        burst_o.count    = 2'd3;
      end else begin
        burst_o.bytes[0] = x;
        burst_o.count    = 2'd1;
      end
      cnt_after = 8'd0;
    end
    cnt_o = item_i.frame_last ? 8'd0 : cnt_after;
  end

endmodule

// ----- src/xdzr_checker.sv -----
// port-level checks for the xor delta zero run encoder
`include "xor_delta_zero_rle_encoder_assert.svh"

module xdzr_checker
  import xdzr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_item_i
);

  // a stalled result holds
  `XDZR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_item_i))

  // a waiting input item stays offered until taken
  `XDZR_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_i, in_valid_i)

  // frame end only marks the last byte of an item
  `XDZR_ASSERT_IMP(a_frame_end_last, clk_i, rst_ni,
                   out_valid_i && out_item_i.frame_end, out_item_i.item_last)

  // a zero byte is always a run marker, followed by its length
  `XDZR_ASSERT_IMP(a_marker_not_last, clk_i, rst_ni,
                   out_valid_i && (out_item_i.out_byte == RUN_MARKER),
                   !out_item_i.item_last)

  // nothing leaves while reset is held
  `XDZR_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni, !out_valid_i)

endmodule

bind xor_delta_zero_rle_encoder xdzr_checker u_xdzr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_i (out_item_o)
);
